### sv/pic_pkg.sv
// Shared types, codes and constants of the priority interrupt controller.
package pic_pkg;

    localparam int NUM_LINES_DEF = 8;
    localparam int MAX_LINES     = 8;
    localparam int LINE_W        = 3;
    localparam int BASE_W        = 5;

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 24;

    localparam logic [7:0]        MASK_RESET = 8'hff;
    localparam logic [BASE_W-1:0] BASE_RESET = 5'd4;
    localparam logic [LINE_W-1:0] LINE_NONE  = 3'd7;

    // command byte decode
    localparam int         CW_INIT_BIT     = 4;
    localparam int         CW_EOI_BIT      = 5;
    localparam int         CW_SPECIFIC_BIT = 6;
    localparam logic [7:0] CW_RSEL_MASK    = 8'h1a;
    localparam logic [7:0] CW_RSEL_CODE    = 8'h0a;
    localparam int         AEOI_BIT        = 1;

    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_READ    = 2'd1,
        CMD_REQUEST = 2'd2,
        CMD_ACK     = 2'd3
    } cmd_t;

    typedef enum logic {
        PORT_CMD  = 1'b0,
        PORT_DATA = 1'b1
    } port_t;

    typedef enum logic [1:0] {
        PHASE_IDLE = 2'd0,
        PHASE_ICW2 = 2'd1,
        PHASE_ICW4 = 2'd2
    } phase_t;

    // priority resolver result
    typedef struct packed {
        logic              hit;
        logic [LINE_W-1:0] line;
    } prio_t;

endpackage

### sv/pic_prio.sv
// Priority resolver: eligible lines and the winning lowest line.
module pic_prio
    import pic_pkg::*;
#(
    parameter int NUM_LINES = NUM_LINES_DEF
) (
    input  logic [NUM_LINES-1:0] pend_i,
    input  logic [NUM_LINES-1:0] isr_i,
    input  logic [NUM_LINES-1:0] mask_i,
    output prio_t                sel_o,
    output logic [NUM_LINES-1:0] onehot_o
);

    logic [NUM_LINES-1:0] isr_low;
    logic [NUM_LINES-1:0] below_isr;
    logic [NUM_LINES-1:0] elig;
    logic [NUM_LINES-1:0] elig_low;
    logic [LINE_W-1:0]    line_idx;

    // lines below the lowest one in service; all lines when none in service
    assign isr_low   = isr_i & (~isr_i + NUM_LINES'(1));
    assign below_isr = isr_low - NUM_LINES'(1);
    assign elig      = pend_i & ~mask_i & below_isr;
    assign elig_low  = elig & (~elig + NUM_LINES'(1));

    always_comb begin
        line_idx = '0;
        for (int k = 0; k < NUM_LINES; k++) begin
            if (elig_low[k]) begin
                line_idx = line_idx | LINE_W'(k);
            end
        end
    end

    assign sel_o.hit  = |elig;
    assign sel_o.line = line_idx;
    assign onehot_o   = elig_low;

endmodule

### sv/priority_interrupt_controller_core.sv
// Top level of the eight-line priority interrupt controller.
//
// One input stream carries commands: register write, register read, request
// line change and interrupt acknowledge (s_tuser). Each accepted beat yields
// exactly one result beat on the master side with the read byte, the
// acknowledge vector (base plus line, base plus 7 when nothing is eligible)
// and the interrupt output level after the command.
// The result is registered at the edge that accepts the command, together
// with the controller state. Throughput is one beat per cycle while the
// receiver takes results; the whole command resolves in one priority encode
// and bit update feeding a second encode for the output level.
// s_tready is high whenever the result register is empty or being drained,
// so a stalled receiver holds the result and stops intake until it is taken.
// Reset (aresetn low, synchronous) empties the result register, clears
// requests and in-service bits, masks all lines and sets vector base 0x20.
module priority_interrupt_controller_core
    import pic_pkg::*;
#(
    parameter int NUM_LINES = NUM_LINES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [7:0] write_data, [10:8] request_line, [11] request_level
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] cmd, [2] reg_port
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] read_data, [15:8] vector, [16] irq
    output logic [M_TDATA_W-1:0] m_tdata
);

    cmd_t                 cmd;
    port_t                reg_port;
    logic [7:0]           wdata;
    logic [LINE_W-1:0]    req_line;
    logic                 req_level;
    logic                 accept;

    logic [NUM_LINES-1:0] pend_reg, pend_next;
    logic [NUM_LINES-1:0] isr_reg, isr_next;
    logic [7:0]           mask_reg, mask_next;
    logic [BASE_W-1:0]    base_reg, base_next;
    phase_t               phase_reg, phase_next;
    logic                 expect_reg, expect_next;
    logic                 aeoi_reg, aeoi_next;
    logic                 ris_reg, ris_next;

    logic                 m_valid_reg;
    logic [7:0]           rd_reg, rd_next;
    logic [7:0]           vec_reg, vec_next;
    logic                 irq_reg;

    prio_t                ack_sel;
    logic [NUM_LINES-1:0] ack_onehot;
    prio_t                irq_sel;

    logic [NUM_LINES-1:0] req_onehot;
    logic [NUM_LINES-1:0] eoi_onehot;
    logic [NUM_LINES-1:0] isr_low;
    logic [MAX_LINES-1:0] pend_ext;
    logic [MAX_LINES-1:0] isr_ext;

    assign cmd       = cmd_t'(s_tuser[1:0]);
    assign reg_port  = port_t'(s_tuser[2]);
    assign wdata     = s_tdata[7:0];
    assign req_line  = s_tdata[10:8];
    assign req_level = s_tdata[11];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // lines at or above NUM_LINES drop out of the decodes
    assign req_onehot = NUM_LINES'(MAX_LINES'(1) << req_line);
    assign eoi_onehot = NUM_LINES'(MAX_LINES'(1) << wdata[2:0]);
    assign isr_low    = isr_reg & (~isr_reg + NUM_LINES'(1));
    assign pend_ext   = MAX_LINES'(pend_reg);
    assign isr_ext    = MAX_LINES'(isr_reg);

    pic_prio #(
        .NUM_LINES(NUM_LINES)
    ) u_prio_ack (
        .pend_i  (pend_reg),
        .isr_i   (isr_reg),
        .mask_i  (mask_reg[NUM_LINES-1:0]),
        .sel_o   (ack_sel),
        .onehot_o(ack_onehot)
    );

    pic_prio #(
        .NUM_LINES(NUM_LINES)
    ) u_prio_irq (
        .pend_i  (pend_next),
        .isr_i   (isr_next),
        .mask_i  (mask_next[NUM_LINES-1:0]),
        .sel_o   (irq_sel),
        .onehot_o()
    );

    always_comb begin
        pend_next   = pend_reg;
        isr_next    = isr_reg;
        mask_next   = mask_reg;
        base_next   = base_reg;
        phase_next  = phase_reg;
        expect_next = expect_reg;
        aeoi_next   = aeoi_reg;
        ris_next    = ris_reg;
        rd_next     = '0;
        vec_next    = '0;
        if (accept) begin
            case (cmd)
                CMD_WRITE: begin
                    if (reg_port == PORT_CMD) begin
                        if (wdata[CW_INIT_BIT]) begin
                            phase_next  = PHASE_ICW2;
                            expect_next = wdata[0];
                            mask_next   = '0;
                            pend_next   = '0;
                            isr_next    = '0;
                        end else if (wdata[CW_EOI_BIT]) begin
                            if (wdata[CW_SPECIFIC_BIT]) begin
                                isr_next = isr_reg & ~eoi_onehot;
                            end else begin
                                isr_next = isr_reg & ~isr_low;
                            end
                        end else if ((wdata & CW_RSEL_MASK) == CW_RSEL_CODE) begin
                            ris_next = wdata[0];
                        end
                    end else begin
                        case (phase_reg)
                            PHASE_ICW2: begin
                                base_next  = wdata[7:3];
                                phase_next = expect_reg ? PHASE_ICW4 : PHASE_IDLE;
                            end
                            PHASE_ICW4: begin
                                aeoi_next  = wdata[AEOI_BIT];
                                phase_next = PHASE_IDLE;
                            end
                            default: begin
                                mask_next = wdata;
                            end
                        endcase
                    end
                end
                CMD_READ: begin
                    if (reg_port == PORT_CMD) begin
                        rd_next = ris_reg ? isr_ext : pend_ext;
                    end else begin
                        rd_next = mask_reg;
                    end
                end
                CMD_REQUEST: begin
                    if (req_level) begin
                        pend_next = pend_reg | req_onehot;
                    end else begin
                        pend_next = pend_reg & ~req_onehot;
                    end
                end
                CMD_ACK: begin
                    if (ack_sel.hit) begin
                        pend_next = pend_reg & ~ack_onehot;
                        if (!aeoi_reg) begin
                            isr_next = isr_reg | ack_onehot;
                        end
                        vec_next = {base_reg, ack_sel.line};
                    end else begin
                        vec_next = {base_reg, LINE_NONE};
                    end
                end
                default: begin
                    pend_next = pend_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= '0;
            isr_reg     <= '0;
            mask_reg    <= MASK_RESET;
            base_reg    <= BASE_RESET;
            phase_reg   <= PHASE_IDLE;
            expect_reg  <= 1'b0;
            aeoi_reg    <= 1'b0;
            ris_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg    <= pend_next;
            isr_reg     <= isr_next;
            mask_reg    <= mask_next;
            base_reg    <= base_next;
            phase_reg   <= phase_next;
            expect_reg  <= expect_next;
            aeoi_reg    <= aeoi_next;
            ris_reg     <= ris_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload: load on every accepted beat, hold otherwise
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg  <= rd_next;
            vec_reg <= vec_next;
            irq_reg <= irq_sel.hit;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, irq_reg, vec_reg, rd_reg};

endmodule

### sv/pic_checker.sv
// Port-level checks of the interrupt controller core, bound to the top level.
module pic_checker
    import pic_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic [S_TUSER_W-1:0] s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // intake open exactly when the result slot is free or draining
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow result slot");

    // every accepted command gives a result the next cycle; reads alone carry data
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[1:0] != CMD_READ)
        |=> m_tvalid && (m_tdata[7:0] == 8'h00))
        else $error("non-read result carries read data");

    // vector is zero for everything but an acknowledge
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[1:0] != CMD_ACK)
        |=> m_tvalid && (m_tdata[15:8] == 8'h00))
        else $error("non-acknowledge result carries a vector");

    // reset empties the result register
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind priority_interrupt_controller_core pic_checker u_pic_checker (.*);
